>>> hdl/gcbr_pkg.sv
// Shared types, constants and constant functions of the gamma/contrast/brightness ramp.
`default_nettype none
package gcbr_pkg;

  localparam int RAMP_ENTRIES_DEF = 256;

  localparam int IDX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int SET_W   = 16;
  localparam int NSPAN_W = 10;   // last entry index, up to 1023
  localparam int DIFF_W  = 12;   // 2*i minus the last entry index, signed
  localparam int KN_W    = 19;
  localparam int DEN_W   = 30;
  localparam int NUM_W   = 32;
  localparam int QUO_W   = 32;
  localparam int X_W     = 33;   // Q0.32 plus the value one
  localparam int P_W     = 6;
  localparam int M_W     = 32;
  localparam int FRAC_W  = 26;
  localparam int E_W     = 32;   // exponent, Q2.30
  localparam int L_W     = 32;   // -log2, Q6.26
  localparam int T_W     = 40;
  localparam int F_W     = 32;
  localparam int Y_W     = 33;
  localparam int OFF_W   = 35;

  localparam int DIV_STEPS = 32;
  localparam int LOG_STEPS = 26;
  localparam int POW_STEPS = 32;

  localparam logic [SET_W-1:0] SET_LO  = 16'd6554;
  localparam logic [SET_W-1:0] SET_HI  = 16'd58982;
  localparam logic [SET_W-1:0] SET_RST = 16'd32768;

  typedef enum logic [1:0] {
    REG_GAMMA      = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_BRIGHTNESS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                    busy;
    logic [KN_W-1:0]         kn;
    logic [DEN_W-1:0]        kdn;
    logic [DEN_W-1:0]        den;
    logic [E_W-1:0]          expo;
    logic signed [OFF_W-1:0] off;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             lo;
    logic             hi;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic              zero;
    logic [P_W-1:0]    p;
    logic [M_W-1:0]    m;
    logic [FRAC_W-1:0] frac;
  } log_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             zero;
    logic [P_W-1:0]   sh;
    logic [F_W-1:0]   f;
    logic [Y_W-1:0]   y;
  } pow_t;

  function automatic logic [SET_W-1:0] clamp_set(input logic [SET_W-1:0] s);
    logic [SET_W-1:0] r;
    r = s;
    if (s < SET_LO) r = SET_LO;
    if (s > SET_HI) r = SET_HI;
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] res;
    logic [63:0] b;
    vv  = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int s = 0; s < 32; s++) begin
      if (vv >= res + b) begin
        vv  = vv - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q0.32, each rung the square root of the one before
  function automatic logic [31:0] ladder_r(input int j);
    logic [63:0] r;
    r = isqrt64(64'h8000_0000_0000_0000);
    for (int k = 1; k < j; k++) begin
      r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/gamma_contrast_brightness_ramp.sv
// Gamma ramp entry generator: contrast, power law and brightness over a chain of cells.
//
// Input: entry_index_i on a valid/ready request channel; one ramp entry per request.
// Output: entry_index_out_o and ramp_value_o (16 bit level for all three colours)
// on a valid/ready channel, in request order.
// Settings: cfg_we_i writes cfg_data_i into register cfg_index_i (0 gamma,
// 1 contrast, 2 brightness); other indexes are dropped.
// Throughput: one request per cycle while in_ready_o is high. Each request passes the
// registered stages and the cell chains (32 quotient, 26 log, 32 power cells).
// After reset and after every settings write, the derived values (contrast
// slope, exponent by a 64 step serial divide, brightness offset) are
// recomputed; in_ready_o stays low until they are done.
// Reset loads all settings with 0.5 and empties the pipeline.
// The output register has a skid stage behind it: when the receiver stalls,
// one more result is caught, then the chain holds and in_ready_o drops.
`default_nettype none
module gamma_contrast_brightness_ramp
  import gcbr_pkg::*;
#(
  parameter int unsigned RAMP_ENTRIES = RAMP_ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [SET_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [IDX_W-1:0] entry_index_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [IDX_W-1:0] entry_index_out_o,
  output      logic [VAL_W-1:0] ramp_value_o
);

  localparam logic signed [DIFF_W-1:0] NSPAN_S = DIFF_W'(RAMP_ENTRIES - 1);
  localparam logic [X_W-1:0] X_ONE = {1'b1, 32'b0};

  cfg_t cfg;
  logic en;

  gcbr_cfg #(.RAMP_ENTRIES(RAMP_ENTRIES)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // ---- s0: contrast slope product
  logic                     s0_v_q;
  logic [IDX_W-1:0]         s0_idx_q;
  logic signed [NUM_W-1:0]  s0_prod_q;
  logic signed [DIFF_W-1:0] dd;
  logic signed [NUM_W-1:0]  prod0;

  assign in_ready_o = en && !cfg.busy;
  assign dd    = $signed({3'b0, entry_index_i, 1'b0}) - NSPAN_S;
  assign prod0 = $signed({1'b0, cfg.kn}) * dd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_v_q <= 1'b0;
    else if (en) s0_v_q <= in_valid_i && !cfg.busy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_idx_q  <= entry_index_i;
      s0_prod_q <= prod0;
    end
  end

  // ---- s1: numerator, saturation flags, quotient seed
  div_t                    div_c [0:DIV_STEPS];
  div_t                    s1_nxt;
  logic                    s1_v_q;
  div_t                    s1_q;
  logic signed [NUM_W-1:0] num;

  always_comb begin
    num        = s0_prod_q + $signed({2'b0, cfg.kdn});
    s1_nxt.vld = s0_v_q;
    s1_nxt.idx = s0_idx_q;
    s1_nxt.lo  = num <= 0;
    s1_nxt.hi  = num >= $signed({2'b0, cfg.den});
    s1_nxt.rem = num[DEN_W-1:0];
    s1_nxt.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= s1_nxt.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_q <= s1_nxt;
  end

  always_comb begin
    div_c[0]     = s1_q;
    div_c[0].vld = s1_v_q;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    gcbr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .den_i  (cfg.den),
      .d_i    (div_c[g]),
      .d_o    (div_c[g+1])
    );
  end

  // ---- s2: x after the contrast clamp, leading one position
  div_t             dq;
  logic [X_W-1:0]   x2;
  logic [P_W-1:0]   p2;
  logic             s2_v_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [X_W-1:0]   s2_x_q;
  logic [P_W-1:0]   s2_p_q;

  assign dq = div_c[DIV_STEPS];

  always_comb begin
    if (dq.lo)      x2 = '0;
    else if (dq.hi) x2 = X_ONE;
    else            x2 = {1'b0, dq.quo};
    p2 = '0;
    for (int b = 0; b < X_W; b++) begin
      if (x2[b]) p2 = P_W'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= dq.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_idx_q <= dq.idx;
      s2_x_q   <= x2;
      s2_p_q   <= p2;
    end
  end

  // ---- s3: normalise mantissa to [1,2) in Q1.31
  log_t        log_c [0:LOG_STEPS];
  log_t        s3_nxt;
  logic        s3_v_q;
  log_t        s3_q;
  logic [63:0] xw, xsh;

  always_comb begin
    xw = {31'b0, s2_x_q};
    if (s2_p_q >= P_W'(31)) xsh = xw >> (s2_p_q - P_W'(31));
    else                    xsh = xw << (P_W'(31) - s2_p_q);
    s3_nxt.vld  = s2_v_q;
    s3_nxt.idx  = s2_idx_q;
    s3_nxt.zero = s2_x_q == '0;
    s3_nxt.p    = s2_p_q;
    s3_nxt.m    = xsh[M_W-1:0];
    s3_nxt.frac = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s3_nxt.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) s3_q <= s3_nxt;
  end

  always_comb begin
    log_c[0]     = s3_q;
    log_c[0].vld = s3_v_q;
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    gcbr_log_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (log_c[g]),
      .d_o    (log_c[g+1])
    );
  end

  // ---- s4: -log2(x) in Q6.26
  log_t             lq;
  logic             s4_v_q;
  logic [IDX_W-1:0] s4_idx_q;
  logic             s4_zero_q;
  logic [L_W-1:0]   s4_l_q;

  assign lq = log_c[LOG_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= lq.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_idx_q  <= lq.idx;
      s4_zero_q <= lq.zero;
      s4_l_q    <= {P_W'(32) - lq.p, 26'b0} - {6'b0, lq.frac};
    end
  end

  // ---- s5: t = e * |log2 x|
  logic             s5_v_q;
  logic [IDX_W-1:0] s5_idx_q;
  logic             s5_zero_q;
  logic [T_W-1:0]   s5_t_q;
  logic [63:0]      tprod;

  assign tprod = {32'b0, cfg.expo} * {32'b0, s4_l_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_idx_q  <= s4_idx_q;
      s5_zero_q <= s4_zero_q;
      s5_t_q    <= tprod[63:24];
    end
  end

  // ---- s6: split t into shift and fraction; far underflow reads as zero
  pow_t pow_c [0:POW_STEPS];
  pow_t s6_nxt;
  logic s6_v_q;
  pow_t s6_q;

  always_comb begin
    s6_nxt.vld  = s5_v_q;
    s6_nxt.idx  = s5_idx_q;
    s6_nxt.zero = s5_zero_q || (s5_t_q[T_W-1:32] >= 8'd33);
    s6_nxt.sh   = s5_t_q[32+P_W-1:32];
    s6_nxt.f    = s5_t_q[F_W-1:0];
    s6_nxt.y    = X_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= s6_nxt.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) s6_q <= s6_nxt;
  end

  always_comb begin
    pow_c[0]     = s6_q;
    pow_c[0].vld = s6_v_q;
  end

  for (genvar g = 0; g < POW_STEPS; g++) begin : g_pow
    gcbr_pow_cell #(.J(g + 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (pow_c[g]),
      .d_o    (pow_c[g+1])
    );
  end

  // ---- s7: integer part shift, brightness offset and clamp
  pow_t                    pq;
  logic [Y_W-1:0]          ysh;
  logic signed [OFF_W-1:0] zsum;
  logic [X_W-1:0]          zc;
  logic                    s7_v_q;
  logic [IDX_W-1:0]        s7_idx_q;
  logic [X_W-1:0]          s7_z_q;

  assign pq = pow_c[POW_STEPS];

  always_comb begin
    ysh  = pq.zero ? '0 : (pq.y >> pq.sh);
    zsum = $signed({2'b0, ysh}) + cfg.off;
    if (zsum < 0)                          zc = '0;
    else if (zsum > $signed({2'b0, X_ONE})) zc = X_ONE;
    else                                   zc = zsum[X_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else if (en) s7_v_q <= pq.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_idx_q <= pq.idx;
      s7_z_q   <= zc;
    end
  end

  // ---- s8: scale to 0..65535
  logic [48:0]      scaled;
  logic             p_v_q;
  logic [IDX_W-1:0] p_idx_q;
  logic [VAL_W-1:0] p_val_q;

  assign scaled = {s7_z_q, 16'b0} - {16'b0, s7_z_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_v_q <= 1'b0;
    else if (en) p_v_q <= s7_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_idx_q <= s7_idx_q;
      p_val_q <= scaled[47:32];
    end
  end

  // ---- output register with skid stage
  logic             out_v_q, skid_v_q;
  logic [IDX_W-1:0] out_idx_q, skid_idx_q;
  logic [VAL_W-1:0] out_val_q, skid_val_q;
  logic             out_free, p_take;

  assign en       = !skid_v_q;
  assign out_free = !out_v_q || out_ready_i;
  assign p_take   = en && p_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || p_take;
      skid_v_q <= 1'b0;
    end else if (p_take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_idx_q <= skid_idx_q;
        out_val_q <= skid_val_q;
      end else begin
        out_idx_q <= p_idx_q;
        out_val_q <= p_val_q;
      end
    end else if (p_take) begin
      skid_idx_q <= p_idx_q;
      skid_val_q <= p_val_q;
    end
  end

  assign out_valid_o       = out_v_q;
  assign entry_index_out_o = out_idx_q;
  assign ramp_value_o      = out_val_q;

  // skid stage only fills behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid holds a result while output is empty");

  // a settings write closes the input for the recompute
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> !in_ready_o)
    else $error("request taken right after settings write");

  // a caught result stays put until the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q && $stable(skid_val_q) && $stable(skid_idx_q))
    else $error("skid result lost under stall");

  // chain holds while the skid stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(p_val_q) && $stable(p_v_q))
    else $error("pipeline moved while skid full");

endmodule
`default_nettype wire

>>> hdl/gcbr_cfg.sv
// Settings registers and the values derived from them, exponent by a serial divider.
`default_nettype none
module gcbr_cfg
  import gcbr_pkg::*;
#(
  parameter int unsigned RAMP_ENTRIES = RAMP_ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [1:0]       index_i,
  input  wire logic [SET_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  localparam logic [NSPAN_W-1:0] NSPAN = NSPAN_W'(RAMP_ENTRIES - 1);
  localparam logic [6:0] CNT_PREP  = 7'd0;
  localparam logic [6:0] CNT_MID   = 7'd1;
  localparam logic [6:0] CNT_INIT  = 7'd2;
  localparam logic [6:0] CNT_LAST  = 7'd66;
  localparam logic [63:0] E_NUM    = 64'd25 << 58;   // 6.25 * 2^60
  localparam logic [34:0] E_BASE   = 35'd25 << 26;   // 0.25 scaled by 2^32 / 0.8^2 path

  logic [SET_W-1:0] gam_q, con_q, bri_q;
  logic             busy_q;
  logic [6:0]       cnt_q;

  logic [SET_W-1:0] cg, cc, cb;
  logic [16:0]      sc;
  logic [16:0]      qg;
  logic signed [17:0] bd;

  logic [KN_W-1:0]  kn_q, kd_q;
  logic [33:0]      qsq_q;
  logic [14:0]      ad_q;
  logic [12:0]      a5_q;
  logic             neg_q;
  logic [30:0]      a5_prod;

  logic [DEN_W-1:0] kdn_q, den_q;
  logic [34:0]      dene_q;
  logic [2:0]       r5;
  logic [31:0]      rtab;
  logic [31:0]      mag;
  logic signed [OFF_W-1:0] off_q;

  logic [63:0] dnum_q;
  logic [34:0] rem_q;
  logic [35:0] rem2;
  logic        ge;
  logic [E_W-1:0] quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gam_q  <= SET_RST;
      con_q  <= SET_RST;
      bri_q  <= SET_RST;
      busy_q <= 1'b1;
      cnt_q  <= CNT_PREP;
    end else if (we_i) begin
      if (index_i == REG_GAMMA)      gam_q <= data_i;
      if (index_i == REG_CONTRAST)   con_q <= data_i;
      if (index_i == REG_BRIGHTNESS) bri_q <= data_i;
      busy_q <= 1'b1;
      cnt_q  <= CNT_PREP;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == CNT_LAST) busy_q <= 1'b0;
    end
  end

  always_comb begin
    cg = clamp_set(gam_q);
    cc = clamp_set(con_q);
    cb = clamp_set(bri_q);
    sc = 17'd65536 - {1'b0, cc};
    qg = 17'd8192 + {1'b0, cg};
    bd = $signed({2'b0, cb}) - 18'sd32768;
    a5_prod = {16'b0, (bd < 0) ? 15'(-bd) : bd[14:0]} * 31'd52429;
  end

  // remainder of |d|/5 as a fraction scaled by 2^18
  always_comb begin
    r5 = 3'(ad_q - 15'({2'b0, a5_q} * 15'd5));
    case (r5)
      3'd1:    rtab = 32'd52428;
      3'd2:    rtab = 32'd104857;
      3'd3:    rtab = 32'd157286;
      3'd4:    rtab = 32'd209715;
      default: rtab = 32'd0;
    endcase
    mag = {1'b0, a5_q, 18'b0} + rtab;
  end

  assign rem2 = {rem_q, dnum_q[63]};
  assign ge   = rem2 >= {1'b0, dene_q};

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (cnt_q)
        CNT_PREP: begin
          kn_q  <= KN_W'(19'd196608 + {sc, 2'b0});
          kd_q  <= KN_W'(19'd458752 - {sc, 2'b0});
          qsq_q <= {17'b0, qg} * {17'b0, qg};
          ad_q  <= (bd < 0) ? 15'(-bd) : bd[14:0];
          neg_q <= bd < 0;
          a5_q  <= a5_prod[30:18];
        end
        CNT_MID: begin
          kdn_q  <= {11'b0, kd_q} * {20'b0, NSPAN};
          den_q  <= {11'b0, kd_q} * {19'b0, NSPAN, 1'b0};
          dene_q <= E_BASE + 35'(qsq_q * 34'd3);
          off_q  <= neg_q ? -$signed({3'b0, mag}) : $signed({3'b0, mag});
        end
        CNT_INIT: begin
          dnum_q <= E_NUM + {30'b0, dene_q[34:1]};
          rem_q  <= '0;
          quo_q  <= '0;
        end
        default: begin
          dnum_q <= {dnum_q[62:0], 1'b0};
          rem_q  <= ge ? 35'(rem2 - {1'b0, dene_q}) : rem2[34:0];
          quo_q  <= {quo_q[E_W-2:0], ge};
        end
      endcase
    end
  end

  always_comb begin
    cfg_o.busy = busy_q;
    cfg_o.kn   = kn_q;
    cfg_o.kdn  = kdn_q;
    cfg_o.den  = den_q;
    cfg_o.expo = quo_q;
    cfg_o.off  = off_q;
  end

endmodule
`default_nettype wire

>>> hdl/gcbr_div_cell.sv
// One restoring step of the contrast quotient.
`default_nettype none
module gcbr_div_cell
  import gcbr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  div_t                  d_i,
  output div_t                  d_o
);

  logic       vld_q;
  div_t       dat_q;
  div_t       nxt;
  logic [DEN_W:0] rem2;
  logic       ge;

  always_comb begin
    rem2 = {d_i.rem, 1'b0};
    ge   = rem2 >= {1'b0, den_i};
    nxt  = d_i;
    nxt.rem = ge ? DEN_W'(rem2 - {1'b0, den_i}) : rem2[DEN_W-1:0];
    nxt.quo = {d_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dat_q <= nxt;
  end

  always_comb begin
    d_o     = dat_q;
    d_o.vld = vld_q;
  end

endmodule
`default_nettype wire

>>> hdl/gcbr_log_cell.sv
// One squaring step of the bit-serial log2: yields one fraction bit.
`default_nettype none
module gcbr_log_cell
  import gcbr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  log_t      d_i,
  output log_t      d_o
);

  logic       vld_q;
  log_t       dat_q;
  log_t       nxt;
  logic [63:0] sq;
  logic [32:0] s;

  always_comb begin
    sq  = {32'b0, d_i.m} * {32'b0, d_i.m};
    s   = sq[63:31];
    nxt = d_i;
    if (s[32]) begin
      nxt.m    = s[32:1];
      nxt.frac = {d_i.frac[FRAC_W-2:0], 1'b1};
    end else begin
      nxt.m    = s[31:0];
      nxt.frac = {d_i.frac[FRAC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dat_q <= nxt;
  end

  always_comb begin
    d_o     = dat_q;
    d_o.vld = vld_q;
  end

endmodule
`default_nettype wire

>>> hdl/gcbr_pow_cell.sv
// One rung of the 2^-f ladder: multiplies by 2^(-2^-J) when the bit of weight 2^-J in f is set.
`default_nettype none
module gcbr_pow_cell
  import gcbr_pkg::*;
#(
  parameter int J = 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  pow_t      d_i,
  output pow_t      d_o
);

  localparam logic [31:0] RUNG = ladder_r(J);

  logic        vld_q;
  pow_t        dat_q;
  pow_t        nxt;
  logic [64:0] prod;

  always_comb begin
    prod = {32'b0, d_i.y} * {33'b0, RUNG};
    nxt  = d_i;
    if (d_i.f[F_W-J]) nxt.y = prod[64:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= d_i.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dat_q <= nxt;
  end

  always_comb begin
    d_o     = dat_q;
    d_o.vld = vld_q;
  end

endmodule
`default_nettype wire
